/* sv/sarm_pkg.sv */
// ----------------------------------------------------------------------------
// Servo arm pose sequencer package
// Shared types, codes and reset values of the arm pose sequencer.
// ----------------------------------------------------------------------------
package sarm_pkg;

   localparam int SERVO_COUNT_DEFAULT   = 5;
   localparam int POSITION_BITS_DEFAULT = 10;

   localparam int ID_BITS        = 8;
   localparam int IDS_BITS       = 40;
   localparam int POSE_BITS      = 50;
   localparam int TOL_BITS       = 10;
   localparam int TIME_BITS      = 16;
   localparam int WRITE_BITS     = 16;
   localparam int POS_IN_BITS    = 10;
   localparam int POS_IN_COUNT   = 5;
   localparam int CSR_DATA_BITS  = 50;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET = 10'd10;
   localparam logic [TIME_BITS-1:0] MOVE_TIME_RESET = 16'd512;
   localparam logic [WRITE_BITS-1:0] TORQUE_ON      = 16'd1;

   localparam logic [1:0] FUNC_NONE    = 2'd0;
   localparam logic [1:0] FUNC_INIT    = 2'd1;
   localparam logic [1:0] FUNC_DEPLOY  = 2'd2;
   localparam logic [1:0] FUNC_RETRACT = 2'd3;

   localparam logic [1:0] REG_TORQUE = 2'd0;
   localparam logic [1:0] REG_TIME   = 2'd1;
   localparam logic [1:0] REG_GOAL   = 2'd2;
   localparam logic [1:0] REG_NONE   = 2'd3;

   localparam logic [1:0] STATUS_DISABLED  = 2'd0;
   localparam logic [1:0] STATUS_MOVING    = 2'd1;
   localparam logic [1:0] STATUS_RETRACTED = 2'd2;
   localparam logic [1:0] STATUS_DEPLOYED  = 2'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SERVO_IDS      = 3'd0,
      CSR_POSE_RETRACTED = 3'd1,
      CSR_POSE_MIDDLE    = 3'd2,
      CSR_POSE_DOWN      = 3'd3,
      CSR_TOLERANCE      = 3'd4,
      CSR_MOVE_TIME      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_OFF       = 3'd0,
      PH_INIT      = 3'd1,
      PH_RETRACTED = 3'd2,
      PH_DEPLOYED  = 3'd3,
      PH_RET1      = 3'd4,
      PH_RET2      = 3'd5,
      PH_DEP1      = 3'd6,
      PH_DEP2      = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      JOB_STATUS = 2'd0,
      JOB_ENABLE = 2'd1,
      JOB_POSE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      POSE_RETRACTED = 2'd0,
      POSE_MIDDLE    = 2'd1,
      POSE_DOWN      = 2'd2
   } pose_sel_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [POS_IN_BITS-1:0] pos_0;
      logic [POS_IN_BITS-1:0] pos_1;
      logic [POS_IN_BITS-1:0] pos_2;
      logic [POS_IN_BITS-1:0] pos_3;
      logic [POS_IN_BITS-1:0] pos_4;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    servo_id;
      logic [1:0]            write_reg;
      logic [WRITE_BITS-1:0] write_value;
      logic [1:0]            arm_status;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [IDS_BITS-1:0]  servo_ids;
      logic [POSE_BITS-1:0] pose_retracted;
      logic [POSE_BITS-1:0] pose_middle;
      logic [POSE_BITS-1:0] pose_down;
      logic [TOL_BITS-1:0]  tolerance;
      logic [TIME_BITS-1:0] move_time;
   } cfg_type;

   typedef struct packed {
      kind_type     kind;
      pose_sel_type pose;
      logic [1:0]   status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [1:0] status_of(phase_type ph);
      logic [1:0] st;
      case (ph)
         PH_OFF:       st = STATUS_DISABLED;
         PH_RETRACTED: st = STATUS_RETRACTED;
         PH_DEPLOYED:  st = STATUS_DEPLOYED;
         default:      st = STATUS_MOVING;
      endcase
      return st;
   endfunction

endpackage

/* sv/servo_arm_pose_sequencer.sv */
// ----------------------------------------------------------------------------
// Servo arm pose sequencer
// A tick is accepted while the two-entry job queue has room. The write
// sequencer takes each job from the queue and sends one result per cycle
// while the output is not stalled: 2*SERVO_COUNT on enable, SERVO_COUNT on a
// move, one status item otherwise, through a registered output stage.
// Synchronous reset sets the phase to off, the registers to their reset values
// and empties the queue and the output stage.
// ----------------------------------------------------------------------------
module servo_arm_pose_sequencer #(
   parameter int SERVO_COUNT   = sarm_pkg::SERVO_COUNT_DEFAULT,
   parameter int POSITION_BITS = sarm_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sarm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sarm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [sarm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sarm_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   sarm_pkg::cfg_type      cfg;
   sarm_pkg::job_type      push_job;
   sarm_pkg::job_type      head_job;
   sarm_pkg::q_status_type q_stat;
   logic                   q_push;
   logic                   q_pop;

   sarm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sarm_front #(
      .SERVO_COUNT   (SERVO_COUNT),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_stat.full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   sarm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   sarm_back #(
      .SERVO_COUNT   (SERVO_COUNT),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_head    (head_job),
      .q_empty   (q_stat.empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("Job pushed into a full queue.");

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("Job popped from an empty queue.");

   a_status_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.write_reg == sarm_pkg::REG_NONE) |-> rsp_data.last)
      else $error("Status item is not the final item of its tick.");

   a_reset_clears_output : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Output valid after reset.");

endmodule

/* sv/sarm_csr.sv */
// ----------------------------------------------------------------------------
// Arm sequencer configuration registers
// Holds servo identifiers, the three poses, tolerance and goal time.
// ----------------------------------------------------------------------------
module sarm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sarm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sarm_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output sarm_pkg::cfg_type                   cfg
);

   sarm_pkg::cfg_type cfg_ff;
   sarm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sarm_pkg::CSR_SERVO_IDS: begin
               cfg_in.servo_ids = csr_write_data[sarm_pkg::IDS_BITS-1:0];
            end
            sarm_pkg::CSR_POSE_RETRACTED: begin
               cfg_in.pose_retracted = csr_write_data[sarm_pkg::POSE_BITS-1:0];
            end
            sarm_pkg::CSR_POSE_MIDDLE: begin
               cfg_in.pose_middle = csr_write_data[sarm_pkg::POSE_BITS-1:0];
            end
            sarm_pkg::CSR_POSE_DOWN: begin
               cfg_in.pose_down = csr_write_data[sarm_pkg::POSE_BITS-1:0];
            end
            sarm_pkg::CSR_TOLERANCE: begin
               cfg_in.tolerance = csr_write_data[sarm_pkg::TOL_BITS-1:0];
            end
            sarm_pkg::CSR_MOVE_TIME: begin
               cfg_in.move_time = csr_write_data[sarm_pkg::TIME_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.servo_ids      <= '0;
         cfg_ff.pose_retracted <= '0;
         cfg_ff.pose_middle    <= '0;
         cfg_ff.pose_down      <= '0;
         cfg_ff.tolerance      <= sarm_pkg::TOLERANCE_RESET;
         cfg_ff.move_time      <= sarm_pkg::MOVE_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sarm_front.sv */
// ----------------------------------------------------------------------------
// Arm sequencer front end
// Accepts control ticks, detects arrival, steps the phase machine and queues
// one job per tick for the write sequencer.
// ----------------------------------------------------------------------------
module sarm_front #(
   parameter int SERVO_COUNT   = sarm_pkg::SERVO_COUNT_DEFAULT,
   parameter int POSITION_BITS = sarm_pkg::POSITION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sarm_pkg::req_type req_data,
   input  sarm_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output sarm_pkg::job_type q_job
);

   localparam int DW = (POSITION_BITS > sarm_pkg::POS_IN_BITS) ?
                       POSITION_BITS : sarm_pkg::POS_IN_BITS;
   localparam int EW = sarm_pkg::POSE_BITS + SERVO_COUNT * POSITION_BITS;

   sarm_pkg::phase_type phase_ff;
   sarm_pkg::phase_type phase_in;

   logic                                 accept;
   logic [sarm_pkg::POSE_BITS-1:0]       target_pose;
   logic [EW-1:0]                        pose_ext;
   logic [sarm_pkg::POS_IN_COUNT-1:0][sarm_pkg::POS_IN_BITS-1:0] pos_all;
   logic [SERVO_COUNT-1:0]               near;
   logic                                 done_auto;
   logic                                 done;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      case (phase_ff)
         sarm_pkg::PH_DEP1, sarm_pkg::PH_RET1: target_pose = cfg.pose_middle;
         sarm_pkg::PH_DEP2:                    target_pose = cfg.pose_down;
         default:                              target_pose = cfg.pose_retracted;
      endcase
   end

   assign pose_ext = EW'(target_pose);
   assign pos_all  = {req_data.pos_4, req_data.pos_3, req_data.pos_2,
                      req_data.pos_1, req_data.pos_0};

   for (genvar i = 0; i < SERVO_COUNT; i++) begin : g_servo
      logic [DW-1:0] target;
      logic [DW-1:0] meas;
      logic [DW-1:0] diff;
      assign target = DW'(pose_ext[i*POSITION_BITS +: POSITION_BITS]);
      if (i < sarm_pkg::POS_IN_COUNT) begin : g_meas
         assign meas = DW'(pos_all[i]);
      end else begin : g_zero
         assign meas = '0;
      end
      assign diff    = (meas >= target) ? (meas - target) : (target - meas);
      assign near[i] = diff < DW'(cfg.tolerance);
   end

   always_comb begin
      case (phase_ff)
         sarm_pkg::PH_INIT: done_auto = 1'b1;
         sarm_pkg::PH_DEP1, sarm_pkg::PH_DEP2,
         sarm_pkg::PH_RET1, sarm_pkg::PH_RET2: done_auto = &near;
         default: done_auto = 1'b0;
      endcase
   end

   assign done = (req_data.func == sarm_pkg::FUNC_NONE) && done_auto;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         sarm_pkg::PH_OFF: begin
            if (req_data.func == sarm_pkg::FUNC_INIT) phase_in = sarm_pkg::PH_INIT;
         end
         sarm_pkg::PH_INIT: begin
            if (done) phase_in = sarm_pkg::PH_RET1;
         end
         sarm_pkg::PH_RETRACTED: begin
            if (req_data.func == sarm_pkg::FUNC_DEPLOY) phase_in = sarm_pkg::PH_DEP1;
         end
         sarm_pkg::PH_DEPLOYED: begin
            if (req_data.func == sarm_pkg::FUNC_RETRACT) phase_in = sarm_pkg::PH_RET1;
         end
         sarm_pkg::PH_DEP1: begin
            if (done) phase_in = sarm_pkg::PH_DEP2;
         end
         sarm_pkg::PH_DEP2: begin
            if (done) phase_in = sarm_pkg::PH_DEPLOYED;
         end
         sarm_pkg::PH_RET1: begin
            if (done) phase_in = sarm_pkg::PH_RET2;
         end
         sarm_pkg::PH_RET2: begin
            if (done) phase_in = sarm_pkg::PH_RETRACTED;
         end
         default: begin
            phase_in = sarm_pkg::PH_OFF;
         end
      endcase
   end

   always_comb begin
      q_job.kind   = sarm_pkg::JOB_STATUS;
      q_job.pose   = sarm_pkg::POSE_MIDDLE;
      q_job.status = sarm_pkg::status_of(phase_in);
      case (phase_ff)
         sarm_pkg::PH_OFF: begin
            if (req_data.func == sarm_pkg::FUNC_INIT) q_job.kind = sarm_pkg::JOB_ENABLE;
         end
         sarm_pkg::PH_INIT: begin
            if (done) q_job.kind = sarm_pkg::JOB_POSE;
         end
         sarm_pkg::PH_RETRACTED: begin
            if (req_data.func == sarm_pkg::FUNC_DEPLOY) q_job.kind = sarm_pkg::JOB_POSE;
         end
         sarm_pkg::PH_DEPLOYED: begin
            if (req_data.func == sarm_pkg::FUNC_RETRACT) q_job.kind = sarm_pkg::JOB_POSE;
         end
         sarm_pkg::PH_DEP1: begin
            if (done) begin
               q_job.kind = sarm_pkg::JOB_POSE;
               q_job.pose = sarm_pkg::POSE_DOWN;
            end
         end
         sarm_pkg::PH_RET1: begin
            if (done) begin
               q_job.kind = sarm_pkg::JOB_POSE;
               q_job.pose = sarm_pkg::POSE_RETRACTED;
            end
         end
         default: begin
            q_job.kind = sarm_pkg::JOB_STATUS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sarm_pkg::PH_OFF;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/sarm_queue.sv */
// ----------------------------------------------------------------------------
// Arm sequencer job queue
// Short first-in first-out buffer of jobs between front end and sequencer.
// ----------------------------------------------------------------------------
module sarm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sarm_pkg::job_type      push_job,
   input  logic                   pop,
   output sarm_pkg::job_type      head_job,
   output sarm_pkg::q_status_type stat
);

   localparam int PW = $clog2(sarm_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(sarm_pkg::QUEUE_DEPTH + 1);

   sarm_pkg::job_type mem_ff [sarm_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [NW-1:0] count_ff;
   logic [NW-1:0] count_in;

   assign stat.full  = (count_ff == NW'(sarm_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* sv/sarm_back.sv */
// ----------------------------------------------------------------------------
// Arm sequencer write sequencer
// Expands each queued job into servo register writes or a status item, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sarm_back #(
   parameter int SERVO_COUNT   = sarm_pkg::SERVO_COUNT_DEFAULT,
   parameter int POSITION_BITS = sarm_pkg::POSITION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  sarm_pkg::cfg_type cfg,
   input  sarm_pkg::job_type q_head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sarm_pkg::rsp_type rsp_data
);

   localparam int CW  = $clog2(2 * SERVO_COUNT);
   localparam int IEW = sarm_pkg::IDS_BITS + SERVO_COUNT * sarm_pkg::ID_BITS;
   localparam int PEW = sarm_pkg::POSE_BITS + SERVO_COUNT * POSITION_BITS;

   logic              busy_ff;
   logic              busy_in;
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;
   sarm_pkg::job_type job_ff;
   sarm_pkg::job_type job_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   sarm_pkg::rsp_type rsp_ff;
   sarm_pkg::rsp_type rsp_in;

   sarm_pkg::job_type              cur;
   sarm_pkg::rsp_type              item;
   logic [CW-1:0]                  sidx;
   logic [sarm_pkg::POSE_BITS-1:0] pose_reg;
   logic [IEW-1:0]                 ids_ext;
   logic [PEW-1:0]                 pose_ext;
   logic [sarm_pkg::ID_BITS-1:0]   sel_id;
   logic [POSITION_BITS-1:0]       sel_pos;
   logic                           have;
   logic                           advance;
   logic                           step;

   assign cur  = busy_ff ? job_ff : q_head;
   assign sidx = (cur.kind == sarm_pkg::JOB_ENABLE) ? (cnt_ff >> 1) : cnt_ff;

   always_comb begin
      case (cur.pose)
         sarm_pkg::POSE_RETRACTED: pose_reg = cfg.pose_retracted;
         sarm_pkg::POSE_DOWN:      pose_reg = cfg.pose_down;
         default:                  pose_reg = cfg.pose_middle;
      endcase
   end

   assign ids_ext  = IEW'(cfg.servo_ids);
   assign pose_ext = PEW'(pose_reg);

   always_comb begin
      sel_id  = '0;
      sel_pos = '0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         if (sidx == CW'(i)) begin
            sel_id  = ids_ext[i*sarm_pkg::ID_BITS +: sarm_pkg::ID_BITS];
            sel_pos = pose_ext[i*POSITION_BITS +: POSITION_BITS];
         end
      end
   end

   always_comb begin
      item.arm_status = cur.status;
      case (cur.kind)
         sarm_pkg::JOB_ENABLE: begin
            item.servo_id    = sel_id;
            item.write_reg   = cnt_ff[0] ? sarm_pkg::REG_TIME : sarm_pkg::REG_TORQUE;
            item.write_value = cnt_ff[0] ? cfg.move_time : sarm_pkg::TORQUE_ON;
            item.last        = (cnt_ff == CW'(2 * SERVO_COUNT - 1));
         end
         sarm_pkg::JOB_POSE: begin
            item.servo_id    = sel_id;
            item.write_reg   = sarm_pkg::REG_GOAL;
            item.write_value = sarm_pkg::WRITE_BITS'(sel_pos);
            item.last        = (cnt_ff == CW'(SERVO_COUNT - 1));
         end
         default: begin
            item.servo_id    = '0;
            item.write_reg   = sarm_pkg::REG_NONE;
            item.write_value = '0;
            item.last        = 1'b1;
         end
      endcase
   end

   assign have    = busy_ff || !q_empty;
   assign advance = !rsp_valid_ff || rsp_ready;
   assign step    = advance && have;
   assign q_pop   = advance && !busy_ff && !q_empty;

   always_comb begin
      busy_in      = step ? !item.last : busy_ff;
      cnt_in       = step ? (item.last ? '0 : cnt_ff + CW'(1)) : cnt_ff;
      job_in       = (step && !busy_ff) ? q_head : job_ff;
      rsp_valid_in = advance ? have : rsp_valid_ff;
      rsp_in       = step ? item : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
